// ----- hw/rtl/video_mode_best_match_select_defines.svh -----
// ----------------------------------------------------------------------------
// Video mode best match select: assertion macros
// Clocked assertion wrappers used by the top-level RTL file of the block.
// ----------------------------------------------------------------------------
`ifndef VIDEO_MODE_BEST_MATCH_SELECT_DEFINES_SVH
`define VIDEO_MODE_BEST_MATCH_SELECT_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Check a property on the rising clock, idle while reset is low
`define VMBM_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check that an expression never holds on the rising clock
`define VMBM_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define VMBM_ASSERT(lbl, clk, rst_n, prop, msg)
`define VMBM_NEVER(lbl, clk, rst_n, expr, msg)
`endif

`endif

// ----- hw/rtl/vmbm_pkg.sv -----
// ----------------------------------------------------------------------------
// Video mode best match select: package
// Word types, register codes, reset values and gap helpers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package vmbm_pkg;

    // End-of-list mode number and the fallback baseline mode
    localparam logic [15:0] END_NUMBER  = 16'hFFFF;
    localparam logic [31:0] BASE_PIXELS = 32'd64000;
    localparam logic [7:0]  BASE_DEPTH  = 8'd8;

    // Register reset values
    localparam logic [15:0] RST_TARGET_WIDTH  = 16'd0;
    localparam logic [15:0] RST_TARGET_HEIGHT = 16'd0;
    localparam logic [7:0]  RST_TARGET_DEPTH  = 8'd8;
    localparam logic [15:0] RST_LFB_MASK      = 16'h0080;
    localparam logic [7:0]  RST_PACKED_MODEL  = 8'd4;
    localparam logic [7:0]  RST_DIRECT_MODEL  = 8'd6;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_TARGET_WIDTH  = 3'd0,
        REG_TARGET_HEIGHT = 3'd1,
        REG_TARGET_DEPTH  = 3'd2,
        REG_LFB_MASK      = 3'd3,
        REG_PACKED_MODEL  = 3'd4,
        REG_DIRECT_MODEL  = 3'd5
    } t_cfg_reg;

    typedef struct packed {
        logic [15:0] mode_id;
        logic        info_ok;
        logic [15:0] attributes;
        logic [7:0]  mem_model;
        logic [15:0] mode_width;
        logic [15:0] mode_height;
        logic [7:0]  mode_depth;
        logic [15:0] line_pitch;
        logic [63:0] color_layout;
        logic [31:0] framebuffer_address;
    } t_mode_desc;

    typedef struct packed {
        logic [15:0] chosen_number;
        logic [7:0]  chosen_model;
        logic [15:0] chosen_width;
        logic [15:0] chosen_height;
        logic [7:0]  chosen_depth;
        logic [15:0] chosen_pitch;
        logic [63:0] chosen_layout;
        logic [31:0] chosen_framebuffer;
    } t_mode_result;

    // Register file contents plus the target pixel count
    typedef struct packed {
        logic [15:0] target_width;
        logic [15:0] target_height;
        logic [7:0]  target_depth;
        logic [15:0] lfb_mask;
        logic [7:0]  packed_code;
        logic [7:0]  direct_code;
        logic [31:0] target_pixels;
    } t_cfg;

    // Scoring of one descriptor against the kept best fit
    typedef struct packed {
        logic        end_mark;
        logic        eligible;
        logic        exact;
        logic        better;
        logic [31:0] pixel_gap;
        logic [8:0]  depth_gap;
    } t_score;

    function automatic logic [31:0] abs_diff32(input logic [31:0] a, input logic [31:0] b);
        return (a >= b) ? (a - b) : (b - a);
    endfunction

    // A shortfall in depth counts double
    function automatic logic [8:0] depth_gap(input logic [7:0] d, input logic [7:0] td);
        logic [7:0] diff;
        diff = (d >= td) ? (d - td) : (td - d);
        return (d >= td) ? {1'b0, diff} : {diff, 1'b0};
    endfunction

endpackage

// ----- hw/rtl/video_mode_best_match_select.sv -----
// ----------------------------------------------------------------------------
// Video mode best match select: top level
// Scans mode descriptors and returns the closest mode to the target.
//
//   Channel   Dir  Handshake                  Word
//   in        in   i_in_valid / o_in_ready    t_mode_desc
//   out       out  o_out_valid / i_out_ready  t_mode_result
//   cfg       in   i_cfg_we                   i_cfg_index, i_cfg_data
//
// One descriptor per cycle while the result register is not stalled; an accepted
// word passes the input register, then scoring into the result register.
// The scoring path is one 16x16 multiply, a subtract and a two-key compare.
// Synchronous active-low reset clears control; no clearing pass.
// A stalled result holds the scoring stage; the input register fills only while empty.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "video_mode_best_match_select_defines.svh"

module video_mode_best_match_select (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  vmbm_pkg::t_mode_desc             i_in_data,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output vmbm_pkg::t_mode_result           o_out_data,
    input  logic                             i_cfg_we,
    input  logic [vmbm_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [vmbm_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import vmbm_pkg::*;

    t_cfg         cfg;
    logic         rearm;
    t_score       sc;
    logic         advance;
    t_mode_result item_res;

    logic         r_in_valid, n_in_valid;
    t_mode_desc   r_in;
    logic         r_out_valid, n_out_valid;
    t_mode_result r_out, n_out;
    logic         r_kept, n_kept;
    logic         r_finished, n_finished;
    logic [31:0]  r_best_pg, n_best_pg;
    logic [8:0]   r_best_dg, n_best_dg;
    t_mode_result r_keep, n_keep;

    vmbm_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg),
        .o_rearm     (rearm)
    );

    vmbm_score u_score (
        .i_desc           (r_in),
        .i_cfg            (cfg),
        .i_kept           (r_kept),
        .i_best_pixel_gap (r_best_pg),
        .i_best_depth_gap (r_best_dg),
        .o_score          (sc)
    );

    // Advance the scoring stage when the result register can take a word
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    assign item_res.chosen_number      = r_in.mode_id;
    assign item_res.chosen_model       = r_in.mem_model;
    assign item_res.chosen_width       = r_in.mode_width;
    assign item_res.chosen_height      = r_in.mode_height;
    assign item_res.chosen_depth       = r_in.mode_depth;
    assign item_res.chosen_pitch       = r_in.line_pitch;
    assign item_res.chosen_layout      = r_in.color_layout;
    assign item_res.chosen_framebuffer = r_in.framebuffer_address;

    // Search update and result selection
    always_comb begin
        n_in_valid  = r_in_valid;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        n_kept      = r_kept;
        n_finished  = r_finished;
        n_best_pg   = r_best_pg;
        n_best_dg   = r_best_dg;
        n_keep      = r_keep;

        if (i_in_valid && o_in_ready) begin
            n_in_valid = 1'b1;
        end else if (advance) begin
            n_in_valid = 1'b0;
        end

        if (advance) begin
            if (sc.end_mark) begin
                // Emit the kept mode (zeros if none) unless an exact match went out, then rearm
                if (!r_finished) begin
                    n_out_valid = 1'b1;
                    n_out       = r_kept ? r_keep : '0;
                end
                n_kept     = 1'b0;
                n_finished = 1'b0;
            end else if (!r_finished && sc.eligible) begin
                if (sc.exact) begin
                    n_keep      = item_res;
                    n_kept      = 1'b1;
                    n_finished  = 1'b1;
                    n_out_valid = 1'b1;
                    n_out       = item_res;
                end else if (sc.better) begin
                    n_keep    = item_res;
                    n_kept    = 1'b1;
                    n_best_pg = sc.pixel_gap;
                    n_best_dg = sc.depth_gap;
                end
            end
        end

        // Restart the search on a new target
        if (rearm) begin
            n_kept     = 1'b0;
            n_finished = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_kept      <= 1'b0;
            r_finished  <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
            r_kept      <= n_kept;
            r_finished  <= n_finished;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_data;
        end
        r_out     <= n_out;
        r_best_pg <= n_best_pg;
        r_best_dg <= n_best_dg;
        r_keep    <= n_keep;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Checks
    `VMBM_ASSERT(a_finished_kept, i_clk, i_rst_n, r_finished |-> r_kept, "finished without a kept mode")
    `VMBM_ASSERT(a_end_rearms, i_clk, i_rst_n, (advance && sc.end_mark) |=> (!r_finished && !r_kept), "end marker did not rearm")
    `VMBM_ASSERT(a_quiet_after_exact, i_clk, i_rst_n, (advance && r_finished && !sc.end_mark) |=> !o_out_valid, "result after exact match")
    `VMBM_ASSERT(a_result_source, i_clk, i_rst_n, $rose(o_out_valid) |-> $past(advance), "result without a scored word")
    `VMBM_NEVER(a_no_overrun, i_clk, i_rst_n, r_in_valid && !advance && i_in_valid && o_in_ready, "input register overrun")

endmodule

// ----- hw/rtl/vmbm_cfg.sv -----
// ----------------------------------------------------------------------------
// Video mode best match select: register file
// Holds the target and filter registers and the target pixel count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vmbm_cfg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [vmbm_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [vmbm_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output vmbm_pkg::t_cfg                   o_cfg,
    output logic                             o_rearm
);
    import vmbm_pkg::*;

    logic [15:0] r_tw, n_tw;
    logic [15:0] r_th, n_th;
    logic [7:0]  r_td, n_td;
    logic [15:0] r_mask, n_mask;
    logic [7:0]  r_pk, n_pk;
    logic [7:0]  r_dc, n_dc;
    logic [31:0] r_want, n_want;

    // Decode a register write
    always_comb begin
        n_tw    = r_tw;
        n_th    = r_th;
        n_td    = r_td;
        n_mask  = r_mask;
        n_pk    = r_pk;
        n_dc    = r_dc;
        o_rearm = 1'b0;
        if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_index))
                REG_TARGET_WIDTH: begin
                    n_tw    = i_cfg_data;
                    o_rearm = 1'b1;
                end
                REG_TARGET_HEIGHT: begin
                    n_th    = i_cfg_data;
                    o_rearm = 1'b1;
                end
                REG_TARGET_DEPTH: begin
                    n_td    = i_cfg_data[7:0];
                    o_rearm = 1'b1;
                end
                REG_LFB_MASK:     n_mask = i_cfg_data;
                REG_PACKED_MODEL: n_pk   = i_cfg_data[7:0];
                REG_DIRECT_MODEL: n_dc   = i_cfg_data[7:0];
                default: ;
            endcase
        end
        // Product of the incoming targets, ready for the first word after a write
        n_want = {16'd0, n_tw} * {16'd0, n_th};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tw   <= RST_TARGET_WIDTH;
            r_th   <= RST_TARGET_HEIGHT;
            r_td   <= RST_TARGET_DEPTH;
            r_mask <= RST_LFB_MASK;
            r_pk   <= RST_PACKED_MODEL;
            r_dc   <= RST_DIRECT_MODEL;
            r_want <= 32'd0;
        end else begin
            r_tw   <= n_tw;
            r_th   <= n_th;
            r_td   <= n_td;
            r_mask <= n_mask;
            r_pk   <= n_pk;
            r_dc   <= n_dc;
            r_want <= n_want;
        end
    end

    assign o_cfg.target_width  = r_tw;
    assign o_cfg.target_height = r_th;
    assign o_cfg.target_depth  = r_td;
    assign o_cfg.lfb_mask      = r_mask;
    assign o_cfg.packed_code   = r_pk;
    assign o_cfg.direct_code   = r_dc;
    assign o_cfg.target_pixels = r_want;

endmodule

// ----- hw/rtl/vmbm_score.sv -----
// ----------------------------------------------------------------------------
// Video mode best match select: descriptor scoring
// Filters one mode and ranks it against the kept best fit or the baseline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vmbm_score (
    input  vmbm_pkg::t_mode_desc i_desc,
    input  vmbm_pkg::t_cfg       i_cfg,
    input  logic                 i_kept,
    input  logic [31:0]          i_best_pixel_gap,
    input  logic [8:0]           i_best_depth_gap,
    output vmbm_pkg::t_score     o_score
);
    import vmbm_pkg::*;

    logic [31:0] pixels;
    logic [31:0] pg;
    logic [8:0]  dg;
    logic [31:0] cmp_pg;
    logic [8:0]  cmp_dg;
    logic        model_ok;

    // Gaps of this mode against the target
    assign pixels = {16'd0, i_desc.mode_width} * {16'd0, i_desc.mode_height};
    assign pg     = abs_diff32(pixels, i_cfg.target_pixels);
    assign dg     = depth_gap(i_desc.mode_depth, i_cfg.target_depth);

    // Compare against the baseline while nothing is kept
    assign cmp_pg = i_kept ? i_best_pixel_gap
                           : abs_diff32(BASE_PIXELS, i_cfg.target_pixels);
    assign cmp_dg = i_kept ? i_best_depth_gap
                           : depth_gap(BASE_DEPTH, i_cfg.target_depth);

    assign model_ok = (i_desc.mem_model == i_cfg.packed_code) ||
                      (i_desc.mem_model == i_cfg.direct_code);

    assign o_score.end_mark  = (i_desc.mode_id == END_NUMBER) || !i_desc.info_ok;
    assign o_score.eligible  = ((i_desc.attributes & i_cfg.lfb_mask) != 16'd0) && model_ok;
    assign o_score.exact     = (i_desc.mode_width  == i_cfg.target_width)  &&
                               (i_desc.mode_height == i_cfg.target_height) &&
                               (i_desc.mode_depth  == i_cfg.target_depth);
    assign o_score.better    = (pg < cmp_pg) || ((pg == cmp_pg) && (dg < cmp_dg));
    assign o_score.pixel_gap = pg;
    assign o_score.depth_gap = dg;

endmodule
